@@ src/mfpp_pkg.sv @@
// mfpp_pkg: shared types and constants for the mocap frame packet parser
// no dependencies; imported by mocap_frame_packet_parser

package mfpp_pkg;

  // longest name kept track of, counting the terminating zero
  localparam int unsigned MAX_NAME_LEN = 256;
  localparam int unsigned NAME_POS_W   = $clog2(MAX_NAME_LEN + 1);

  // message id that carries frame data
  localparam logic [15:0] FRAME_MSG_ID = 16'd7;

  // marker set name that is passed on
  localparam int unsigned KEY_LEN = 8;
  localparam logic [7:0] KEY_NAME [KEY_LEN] = '{
    8'h6b, 8'h65, 8'h79, 8'h62, 8'h6f, 8'h61, 8'h72, 8'h64
  };

  // record kinds
  localparam logic [1:0] KIND_KEY_MARKER   = 2'd0;
  localparam logic [1:0] KIND_UNLABELED    = 2'd1;
  localparam logic [1:0] KIND_RIGID_BODY   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } mfpp_in_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] quat_x;
    logic [31:0] quat_y;
    logic [31:0] quat_z;
    logic [31:0] quat_w;
  } mfpp_out_t;

endpackage

@@ src/mocap_frame_packet_parser.sv @@
// mocap_frame_packet_parser: byte-wide parser of motion-capture frame datagrams
// depends on mfpp_pkg (payload structs, name constant, record kinds)
//
// usage:
//   in_*  : one datagram byte per transfer; first_byte set on the first byte of
//           a packet restarts the parser on that byte
//   out_* : one record per transfer: keyboard-set markers (kind 0), unlabeled
//           markers (kind 1) and rigid body poses (kind 2); floats as raw bits
//   each byte is handled in the cycle it is taken; a record produced by a
//   byte is shown on out_* from the next cycle on
//   throughput: one byte per cycle, limited only by the single output
//   register; the next byte is taken while a record waits, as long as the
//   receiver takes the waiting record in that same cycle
//   when the receiver stalls with a record held, in_ready drops and stays low
//   until that record is transferred, so nothing is lost or repeated
//   reset (rst_n low, synchronous) returns the parser to idle: bytes before
//   the first flagged byte are dropped, and the output register is empty
//   packets with a message id other than 7 are ignored after their byte count
//   field until the next flagged byte

module mocap_frame_packet_parser
  import mfpp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mfpp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output mfpp_out_t out_data
);

  // parser phases
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_MSGID  = 4'd1;
  localparam logic [3:0] PH_NBYTES = 4'd2;
  localparam logic [3:0] PH_FRAME  = 4'd3;
  localparam logic [3:0] PH_NSETS  = 4'd4;
  localparam logic [3:0] PH_NAME   = 4'd5;
  localparam logic [3:0] PH_NMARK  = 4'd6;
  localparam logic [3:0] PH_MARK   = 4'd7;
  localparam logic [3:0] PH_NOTHER = 4'd8;
  localparam logic [3:0] PH_OTHER  = 4'd9;
  localparam logic [3:0] PH_NRB    = 4'd10;
  localparam logic [3:0] PH_RB     = 4'd11;
  localparam logic [3:0] PH_RBPAR  = 4'd12;
  localparam logic [3:0] PH_DONE   = 4'd13;

  localparam logic [NAME_POS_W:0] NAME_LIMIT = (NAME_POS_W + 1)'(MAX_NAME_LEN - 1);
  localparam logic [NAME_POS_W-1:0] NAME_MAX = NAME_POS_W'(MAX_NAME_LEN);
  localparam logic [NAME_POS_W-1:0] KEY_END  = NAME_POS_W'(KEY_LEN);

  // parser state
  logic [3:0]            phase_r,      phase_nxt;
  logic [1:0]            bif_r,        bif_nxt;
  logic [31:0]           shift_r,      shift_nxt;
  logic [15:0]           msg_id_r,     msg_id_nxt;
  logic [31:0]           sets_left_r,  sets_left_nxt;
  logic [31:0]           items_left_r, items_left_nxt;
  logic [3:0]            word_r,       word_nxt;
  logic [NAME_POS_W-1:0] name_pos_r,   name_pos_nxt;
  logic                  name_ok_r,    name_ok_nxt;
  logic [31:0]           words_r [7];
  logic [31:0]           words_nxt [7];

  // output register
  logic      out_valid_r;
  mfpp_out_t out_data_r;

  // per-byte working signals
  logic        in_fire;
  logic [3:0]  ph;          // phase after a possible restart
  logic [1:0]  bif;
  logic [31:0] shift_cur;
  logic [31:0] shifted;
  logic [2:0]  field_len;
  logic        field_done;
  logic        uses_field;
  logic [31:0] fv;          // completed field value
  logic [7:0]  b;
  logic        res_valid;
  mfpp_out_t   res;
  logic [3:0]  word_inc;
  logic [31:0] items_dec;
  logic [31:0] sets_dec;
  logic [2:0]  rb_idx;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shared field collector: little-endian, two or four bytes
  assign b         = in_data.data_byte;
  assign ph        = in_data.first_byte ? PH_MSGID : phase_r;
  assign bif       = in_data.first_byte ? 2'd0 : bif_r;
  assign shift_cur = in_data.first_byte ? 32'd0 : shift_r;
  assign shifted   = shift_cur | ({24'd0, b} << {bif, 3'b000});
  assign field_len = (ph == PH_MSGID || ph == PH_NBYTES || ph == PH_RBPAR) ? 3'd2 : 3'd4;
  assign field_done = ({1'b0, bif} + 3'd1) >= field_len;
  assign uses_field = !(ph == PH_IDLE || ph == PH_NAME || ph == PH_DONE);
  assign fv         = shifted;

  assign word_inc  = word_r + 4'd1;
  assign items_dec = items_left_r - 32'd1;
  assign sets_dec  = sets_left_r - 32'd1;
  assign rb_idx    = 3'(word_r - 4'd1);

  always_comb begin
    phase_nxt      = phase_r;
    bif_nxt        = bif_r;
    shift_nxt      = shift_r;
    msg_id_nxt     = msg_id_r;
    sets_left_nxt  = sets_left_r;
    items_left_nxt = items_left_r;
    word_nxt       = word_r;
    name_pos_nxt   = name_pos_r;
    name_ok_nxt    = name_ok_r;
    words_nxt      = words_r;
    res_valid      = 1'b0;
    res            = '0;

    if (in_fire) begin
      phase_nxt = ph;
      bif_nxt   = bif;
      shift_nxt = shift_cur;
      if (uses_field) begin
        if (field_done) begin
          shift_nxt = 32'd0;
          bif_nxt   = 2'd0;
        end else begin
          shift_nxt = shifted;
          bif_nxt   = bif + 2'd1;
        end
      end

      unique case (ph)
        PH_MSGID: begin
          if (field_done) begin
            msg_id_nxt = fv[15:0];
            phase_nxt  = PH_NBYTES;
          end
        end
        PH_NBYTES: begin
          if (field_done) begin
            phase_nxt = (msg_id_r == FRAME_MSG_ID) ? PH_FRAME : PH_DONE;
          end
        end
        PH_FRAME: begin
          if (field_done) begin
            phase_nxt = PH_NSETS;
          end
        end
        PH_NSETS: begin
          if (field_done) begin
            if (fv == 32'd0 || fv[31]) begin
              phase_nxt = PH_NOTHER;
            end else begin
              sets_left_nxt = fv;
              phase_nxt     = PH_NAME;
              name_pos_nxt  = '0;
              name_ok_nxt   = 1'b1;
            end
          end
        end
        PH_NAME: begin
          // name compared on the fly against the key, one byte per transfer
          if (b == 8'd0) begin
            if (name_pos_r != KEY_END) begin
              name_ok_nxt = 1'b0;
            end
            phase_nxt = PH_NMARK;
          end else begin
            if (name_pos_r >= KEY_END || KEY_NAME[name_pos_r[2:0]] != b) begin
              name_ok_nxt = 1'b0;
            end
            // overlong names never match
            if (({1'b0, name_pos_r} + 1'b1) >= NAME_LIMIT) begin
              name_ok_nxt = 1'b0;
            end
            if (name_pos_r < NAME_MAX) begin
              name_pos_nxt = name_pos_r + 1'b1;
            end
          end
        end
        PH_NMARK: begin
          if (field_done) begin
            if (fv == 32'd0 || fv[31]) begin
              sets_left_nxt = sets_dec;
              if (sets_dec != 32'd0) begin
                phase_nxt    = PH_NAME;
                name_pos_nxt = '0;
                name_ok_nxt  = 1'b1;
              end else begin
                phase_nxt = PH_NOTHER;
              end
            end else begin
              items_left_nxt = fv;
              word_nxt       = 4'd0;
              phase_nxt      = PH_MARK;
            end
          end
        end
        PH_MARK, PH_OTHER: begin
          if (field_done) begin
            words_nxt[word_r[1:0]] = fv;
            word_nxt = word_inc;
            if (word_inc >= 4'd3) begin
              word_nxt   = 4'd0;
              res.pos_x  = words_nxt[0];
              res.pos_y  = words_nxt[1];
              res.pos_z  = words_nxt[2];
              if (ph == PH_OTHER) begin
                res.record_kind = KIND_UNLABELED;
                res_valid       = 1'b1;
              end else begin
                res.record_kind = KIND_KEY_MARKER;
                res_valid       = name_ok_r;
              end
              items_left_nxt = items_dec;
              if (items_dec == 32'd0) begin
                if (ph == PH_OTHER) begin
                  phase_nxt = PH_NRB;
                end else begin
                  sets_left_nxt = sets_dec;
                  if (sets_dec != 32'd0) begin
                    phase_nxt    = PH_NAME;
                    name_pos_nxt = '0;
                    name_ok_nxt  = 1'b1;
                  end else begin
                    phase_nxt = PH_NOTHER;
                  end
                end
              end
            end
          end
        end
        PH_NOTHER, PH_NRB: begin
          if (field_done) begin
            if (fv == 32'd0 || fv[31]) begin
              phase_nxt = (ph == PH_NOTHER) ? PH_NRB : PH_DONE;
            end else begin
              items_left_nxt = fv;
              word_nxt       = 4'd0;
              phase_nxt      = (ph == PH_NOTHER) ? PH_OTHER : PH_RB;
            end
          end
        end
        PH_RB: begin
          // words: id, x, y, z, qx, qy, qz, qw, error
          if (field_done) begin
            if (word_r >= 4'd1 && word_r <= 4'd7) begin
              words_nxt[rb_idx] = fv;
            end
            if (word_r == 4'd7) begin
              res.record_kind = KIND_RIGID_BODY;
              res.pos_x       = words_nxt[0];
              res.pos_y       = words_nxt[1];
              res.pos_z       = words_nxt[2];
              res.quat_x      = words_nxt[3];
              res.quat_y      = words_nxt[4];
              res.quat_z      = words_nxt[5];
              res.quat_w      = words_nxt[6];
              res_valid       = 1'b1;
            end
            word_nxt = word_inc;
            if (word_inc >= 4'd9) begin
              word_nxt  = 4'd0;
              phase_nxt = PH_RBPAR;
            end
          end
        end
        PH_RBPAR: begin
          if (field_done) begin
            items_left_nxt = items_dec;
            phase_nxt      = (items_dec == 32'd0) ? PH_DONE : PH_RB;
          end
        end
        default: begin
          // idle or done: byte dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bif_r        <= 2'd0;
      shift_r      <= 32'd0;
      msg_id_r     <= 16'd0;
      sets_left_r  <= 32'd0;
      items_left_r <= 32'd0;
      word_r       <= 4'd0;
      name_pos_r   <= '0;
      name_ok_r    <= 1'b1;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 7; i++) begin
        words_r[i] <= 32'd0;
      end
    end else begin
      phase_r      <= phase_nxt;
      bif_r        <= bif_nxt;
      shift_r      <= shift_nxt;
      msg_id_r     <= msg_id_nxt;
      sets_left_r  <= sets_left_nxt;
      items_left_r <= items_left_nxt;
      word_r       <= word_nxt;
      name_pos_r   <= name_pos_nxt;
      name_ok_r    <= name_ok_nxt;
      words_r      <= words_nxt;
      // load a new record, or empty the register once the receiver takes it
      if (in_fire && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // record payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_data_r <= res;
    end
  end

endmodule

@@ sim/mocap_frame_packet_parser_tb.sv @@
// mocap_frame_packet_parser_tb: self-checking bench for the mocap frame packet parser
// depends on mfpp_pkg and mocap_frame_packet_parser; streams datagram bytes
// with random pacing and checks every record against a built-in parser model

module mocap_frame_packet_parser_tb;
  import mfpp_pkg::*;

  localparam int unsigned RUN_LIMIT   = 400000;
  localparam int unsigned STREAM_BYTES = 1650;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned PRESSURE_AT = 400;
  localparam int unsigned PRESSURE_LEN = 400;

  // where the byte-level model stands inside a datagram
  typedef enum logic [3:0] {
    PH_IDLE, PH_MSG_ID, PH_BYTE_COUNT, PH_FRAME_NUM, PH_SET_COUNT, PH_SET_NAME,
    PH_MARKER_COUNT, PH_MARKERS, PH_UNLAB_COUNT, PH_UNLAB, PH_BODY_COUNT,
    PH_BODY, PH_BODY_PARAMS, PH_DONE
  } parse_phase_e;

  class record_scoreboard;
    parse_phase_e phase;
    int unsigned  byte_idx;
    logic [31:0]  shift_reg;
    logic [15:0]  msg_id;
    logic [31:0]  sets_left;
    logic [31:0]  items_left;
    int unsigned  word_idx;
    int unsigned  name_pos;
    bit           name_ok;
    logic [31:0]  words [7];
    mfpp_out_t    expected_records [$];
    int unsigned  failures;
    int unsigned  records_checked;

    function new();
      phase = PH_IDLE;
      byte_idx = 0;
      shift_reg = '0;
      msg_id = '0;
      sets_left = '0;
      items_left = '0;
      word_idx = 0;
      name_pos = 0;
      name_ok = 1'b1;
      foreach (words[k]) words[k] = '0;
      failures = 0;
      records_checked = 0;
    endfunction

    function int pending();
      return expected_records.size();
    endfunction

    // gather one little-endian byte, report when an nb-byte field is whole
    function bit collect(input logic [7:0] b, input int unsigned nb,
                         output logic [31:0] val);
      val = '0;
      shift_reg |= 32'(b) << (8 * byte_idx);
      if (byte_idx + 1 >= nb) begin
        val = shift_reg;
        shift_reg = '0;
        byte_idx = 0;
        return 1'b1;
      end
      byte_idx++;
      return 1'b0;
    endfunction

    // zero or bit 31 set both mean an empty list
    function bit empty_count(input logic [31:0] c);
      return (c == 32'd0) || c[31];
    endfunction

    function void start_name();
      phase = PH_SET_NAME;
      name_pos = 0;
      name_ok = 1'b1;
    endfunction

    function void finish_set();
      sets_left = sets_left - 1;
      if (sets_left != 0) start_name();
      else phase = PH_UNLAB_COUNT;
    endfunction

    function void emit(input logic [1:0] kind, input bit pose);
      mfpp_out_t r;
      r.record_kind = kind;
      r.pos_x  = words[0];
      r.pos_y  = words[1];
      r.pos_z  = words[2];
      r.quat_x = pose ? words[3] : 32'd0;
      r.quat_y = pose ? words[4] : 32'd0;
      r.quat_z = pose ? words[5] : 32'd0;
      r.quat_w = pose ? words[6] : 32'd0;
      expected_records.insert(expected_records.size(), r);
    endfunction

    function void note_byte(input mfpp_in_t item);
      logic [31:0] v;
      logic [7:0]  b;
      b = item.data_byte;
      if (item.first_byte) begin
        phase = PH_MSG_ID;
        byte_idx = 0;
        shift_reg = '0;
      end
      case (phase)
        PH_MSG_ID: begin
          if (collect(b, 2, v)) begin
            msg_id = v[15:0];
            phase = PH_BYTE_COUNT;
          end
        end
        PH_BYTE_COUNT: begin
          if (collect(b, 2, v)) phase = (msg_id == FRAME_MSG_ID) ? PH_FRAME_NUM : PH_DONE;
        end
        PH_FRAME_NUM: begin
          if (collect(b, 4, v)) phase = PH_SET_COUNT;
        end
        PH_SET_COUNT: begin
          if (collect(b, 4, v)) begin
            if (empty_count(v)) begin
              phase = PH_UNLAB_COUNT;
            end else begin
              sets_left = v;
              start_name();
            end
          end
        end
        PH_SET_NAME: begin
          if (b == 8'd0) begin
            if (name_pos != KEY_LEN) name_ok = 1'b0;
            phase = PH_MARKER_COUNT;
          end else begin
            if (name_pos >= KEY_LEN || KEY_NAME[name_pos % KEY_LEN] != b) name_ok = 1'b0;
            // overlong names never match
            if (name_pos + 1 >= MAX_NAME_LEN - 1) name_ok = 1'b0;
            if (name_pos < MAX_NAME_LEN) name_pos++;
          end
        end
        PH_MARKER_COUNT: begin
          if (collect(b, 4, v)) begin
            if (empty_count(v)) begin
              finish_set();
            end else begin
              items_left = v;
              word_idx = 0;
              phase = PH_MARKERS;
            end
          end
        end
        PH_MARKERS, PH_UNLAB: begin
          if (collect(b, 4, v)) begin
            words[word_idx % 3] = v;
            word_idx++;
            if (word_idx >= 3) begin
              word_idx = 0;
              if (phase == PH_UNLAB) emit(KIND_UNLABELED, 1'b0);
              else if (name_ok) emit(KIND_KEY_MARKER, 1'b0);
              items_left = items_left - 1;
              if (items_left == 0) begin
                if (phase == PH_UNLAB) phase = PH_BODY_COUNT;
                else finish_set();
              end
            end
          end
        end
        PH_UNLAB_COUNT, PH_BODY_COUNT: begin
          if (collect(b, 4, v)) begin
            if (empty_count(v)) begin
              phase = (phase == PH_UNLAB_COUNT) ? PH_BODY_COUNT : PH_DONE;
            end else begin
              items_left = v;
              word_idx = 0;
              phase = (phase == PH_UNLAB_COUNT) ? PH_UNLAB : PH_BODY;
            end
          end
        end
        PH_BODY: begin
          // word 0 is the id, 1..7 the pose, 8 the mean error
          if (collect(b, 4, v)) begin
            if (word_idx >= 1 && word_idx <= 7) words[word_idx - 1] = v;
            if (word_idx == 7) emit(KIND_RIGID_BODY, 1'b1);
            word_idx++;
            if (word_idx >= 9) begin
              word_idx = 0;
              phase = PH_BODY_PARAMS;
            end
          end
        end
        PH_BODY_PARAMS: begin
          if (collect(b, 2, v)) begin
            items_left = items_left - 1;
            phase = (items_left == 0) ? PH_DONE : PH_BODY;
          end
        end
        default: ;
      endcase
    endfunction

    function void flag(input string msg);
      failures++;
      if (failures <= REPORT_MAX) $display("%s", msg);
    endfunction

    function void check_record(input mfpp_out_t got);
      mfpp_out_t exp;
      string     bad;
      records_checked++;
      if (expected_records.size() == 0) begin
        flag($sformatf("record %0d: unexpected transfer, kind %0d pos %h %h %h",
                       records_checked, got.record_kind, got.pos_x, got.pos_y, got.pos_z));
        return;
      end
      exp = expected_records.pop_front();
      bad = "";
      if (got.record_kind !== exp.record_kind) bad = {bad, " record_kind"};
      if (got.pos_x  !== exp.pos_x)  bad = {bad, " pos_x"};
      if (got.pos_y  !== exp.pos_y)  bad = {bad, " pos_y"};
      if (got.pos_z  !== exp.pos_z)  bad = {bad, " pos_z"};
      if (got.quat_x !== exp.quat_x) bad = {bad, " quat_x"};
      if (got.quat_y !== exp.quat_y) bad = {bad, " quat_y"};
      if (got.quat_z !== exp.quat_z) bad = {bad, " quat_z"};
      if (got.quat_w !== exp.quat_w) bad = {bad, " quat_w"};
      if (bad != "") begin
        flag($sformatf({"record %0d mismatch in%s\n",
                        "  expected kind %0d pos %h %h %h quat %h %h %h %h\n",
                        "  actual   kind %0d pos %h %h %h quat %h %h %h %h"},
                       records_checked, bad,
                       exp.record_kind, exp.pos_x, exp.pos_y, exp.pos_z,
                       exp.quat_x, exp.quat_y, exp.quat_z, exp.quat_w,
                       got.record_kind, got.pos_x, got.pos_y, got.pos_z,
                       got.quat_x, got.quat_y, got.quat_z, got.quat_w));
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  mfpp_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  mfpp_out_t out_data;

  record_scoreboard sb = new();
  mfpp_in_t         byte_stream [$];
  int unsigned      bytes_sent = 0;
  int unsigned      cycle_cnt = 0;
  int unsigned      hold_left = 0;
  bit               pressure_done = 1'b0;
  int               rx_gap;

  mocap_frame_packet_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------
  // datagram builders
  // ---------------------------------------------------------------------
  function automatic void push_byte(input logic [7:0] b, input bit first = 1'b0);
    mfpp_in_t item;
    item.data_byte = b;
    item.first_byte = first;
    byte_stream.insert(byte_stream.size(), item);
  endfunction

  function automatic void push_le(input logic [31:0] value, input int nb);
    for (int k = 0; k < nb; k++) push_byte(value[8*k +: 8]);
  endfunction

  function automatic void push_header(input logic [15:0] id, input logic [15:0] len);
    push_byte(id[7:0], 1'b1);
    push_byte(id[15:8]);
    push_le(32'(len), 2);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // small counts, with zero and negative ones mixed in
  function automatic logic [31:0] rand_count(input int maxn);
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'h8000_0000 | $urandom;
      default: return $urandom_range(1, maxn);
    endcase
  endfunction

  function automatic void push_triple();
    repeat (3) push_le(rand_word(), 4);
  endfunction

  function automatic void push_body();
    push_le($urandom, 4);
    repeat (7) push_le(rand_word(), 4);
    push_le($urandom, 4);
    push_le($urandom, 2);
  endfunction

  function automatic void push_keyboard();
    for (int k = 0; k < KEY_LEN; k++) push_byte(KEY_NAME[k]);
  endfunction

  // zero-terminated set name: the wanted one, empty, random or a near miss
  function automatic void push_name(input int style);
    int cut;
    int pick;
    case (style)
      0, 1, 2, 3: push_keyboard();
      4: ;
      5: repeat ($urandom_range(1, 10)) push_byte(8'($urandom_range(1, 255)));
      default: begin
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
          // prefix of the wanted name
          cut = $urandom_range(1, KEY_LEN - 1);
          for (int k = 0; k < cut; k++) push_byte(KEY_NAME[k]);
        end else if (pick == 1) begin
          push_keyboard();
          push_byte(8'($urandom_range(1, 255)));
        end else begin
          // one letter swapped for an upper-case one
          cut = $urandom_range(0, KEY_LEN - 1);
          for (int k = 0; k < KEY_LEN; k++)
            push_byte((k == cut) ? 8'(8'h41 + $urandom_range(0, 25)) : KEY_NAME[k]);
        end
      end
    endcase
    push_byte(8'h00);
  endfunction

  function automatic void push_frame(input bit long_name);
    logic [31:0] n;
    logic [31:0] m;
    push_header(FRAME_MSG_ID, 16'($urandom));
    push_le($urandom, 4);
    n = rand_count(3);
    push_le(n, 4);
    for (int s = 0; s < (n[31] ? 0 : n); s++) begin
      if (long_name && s == 0) begin
        // reaches or runs past the name buffer length, consumed up to its zero
        repeat ($urandom_range(MAX_NAME_LEN - 2, MAX_NAME_LEN + 44))
          push_byte(8'($urandom_range(1, 255)));
        push_byte(8'h00);
      end else begin
        push_name($urandom_range(0, 7));
      end
      m = rand_count(3);
      push_le(m, 4);
      repeat (m[31] ? 0 : m) push_triple();
    end
    n = rand_count(3);
    push_le(n, 4);
    repeat (n[31] ? 0 : n) push_triple();
    n = rand_count(3);
    push_le(n, 4);
    repeat (n[31] ? 0 : n) push_body();
    // trailing bytes are ignored
    repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
  endfunction

  function automatic void push_foreign();
    logic [15:0] id;
    id = 16'($urandom);
    if (id == FRAME_MSG_ID) id = id ^ 16'h0100;
    push_header(id, 16'($urandom));
    repeat ($urandom_range(0, 6)) push_byte(8'($urandom));
  endfunction

  function automatic void push_noise();
    repeat ($urandom_range(1, 8)) push_byte(8'($urandom), $urandom_range(0, 9) == 0);
  endfunction

  function automatic void build_stimulus();
    int unsigned target;
    int unsigned frames;
    int unsigned long_at;
    int unsigned cut;
    int unsigned start;
    int r;

    // stray bytes before any packet start
    push_byte(8'h00);
    push_byte(8'hFF);
    // foreign message id: rest of the packet ignored
    push_header(16'h0107, 16'hFFFF);
    push_byte(8'h07);
    // negative set count, one unlabeled marker at extremes, empty body list
    push_header(FRAME_MSG_ID, 16'h0000);
    push_le(32'hFFFF_FFFF, 4);
    push_le(32'h8000_0000, 4);
    push_le(32'd1, 4);
    push_le(32'h0000_0000, 4);
    push_le(32'hFFFF_FFFF, 4);
    push_le(32'h8000_0000, 4);
    push_le(32'd0, 4);
    push_byte(8'h5A);
    // cut inside a set name, restarted by the next packet
    push_header(FRAME_MSG_ID, 16'h1234);
    push_le(32'd0, 4);
    push_le(32'd1, 4);
    push_byte(KEY_NAME[0]);
    // wanted set with one marker, no unlabeled, one rigid body
    push_header(FRAME_MSG_ID, 16'h0000);
    push_le($urandom, 4);
    push_le(32'd1, 4);
    push_name(0);
    push_le(32'd1, 4);
    push_triple();
    push_le(32'd0, 4);
    push_le(32'd1, 4);
    push_body();

    target = STREAM_BYTES;
    frames = 0;
    long_at = $urandom_range(2, 6);
    while (byte_stream.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        push_frame(frames == long_at);
        frames++;
      end else if (r < 84) begin
        // broken frame, cut short before its end
        start = byte_stream.size();
        push_frame(1'b0);
        cut = $urandom_range(1, byte_stream.size() - start - 1);
        if (cut > 40) cut = $urandom_range(1, 40);
        repeat (cut) void'(byte_stream.pop_back());
      end else if (r < 92) begin
        push_foreign();
      end else begin
        push_noise();
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // sender: one byte per transfer, random gaps, quiet stretches
  // ---------------------------------------------------------------------
  initial begin
    int gap;
    build_stimulus();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int i = 0; i < byte_stream.size(); i++) begin
      gap = pick_gap(((i / 100) % 5) == 4);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid = 1'b1;
      in_data = byte_stream[i];
      do @(posedge clk); while (!in_ready);
      sb.note_byte(in_data);
      bytes_sent++;
      @(negedge clk);
    end
    in_valid = 1'b0;

    // drain, then give the block time to show anything extra
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // receiver pacing: random stalls, quiet stretches, one long hold-off
  // while the sender keeps offering bytes
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready = 1'b0;
    end else if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (!pressure_done && bytes_sent >= PRESSURE_AT) begin
      pressure_done = 1'b1;
      out_ready = 1'b0;
      hold_left = PRESSURE_LEN - 1;
    end else begin
      rx_gap = pick_gap(((cycle_cnt / 150) % 5) == 4);
      if (rx_gap > 0) begin
        out_ready = 1'b0;
        hold_left = unsigned'(rx_gap - 1);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // record monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_record(out_data);
  end

  // run limit
  initial begin
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
src/mfpp_pkg.sv
src/mocap_frame_packet_parser.sv
sim/mocap_frame_packet_parser_tb.sv
